// ----- rtl/core/bsc_pkg.sv -----
package bsc_pkg;

   localparam int PROCESSES_DEF = 16;
   localparam int RESOURCES_DEF = 32;

   // item field widths
   localparam int OP_W     = 2;
   localparam int PROC_W   = 4;
   localparam int RES_W    = 5;
   localparam int AMOUNT_W = 9;
   localparam int UNIT_W   = 8;
   localparam int COUNT_W  = 5;
   // widened index for range checks against parameters up to 127
   localparam int IDX_W    = 7;

   typedef enum logic [OP_W-1:0] {
      OP_TOTAL   = 2'd0,
      OP_CLAIM   = 2'd1,
      OP_REQUEST = 2'd2
   } op_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_WRD,
      ST_WUSE,
      ST_CRD,
      ST_CUSE,
      ST_ARD,
      ST_AUSE,
      ST_DECIDE,
      ST_MRD,
      ST_MUSE,
      ST_PCLR,
      ST_OUT
   } state_type;

   typedef struct packed {
      state_type state;
      logic      new_pass;
   } ctl_type;

   typedef struct packed {
      logic last_go;
      logic proc_ok;
      logic fin;
      logic fail;
      logic progress;
      logic grant;
      logic rsp_free;
   } sts_type;

   function automatic logic [UNIT_W-1:0] clamp_unit(input logic signed [AMOUNT_W:0] v);
      logic [UNIT_W-1:0] r;
      if (v < 0) begin
         r = '0;
      end else if (v > 10'sd255) begin
         r = '1;
      end else begin
         r = v[UNIT_W-1:0];
      end
      return r;
   endfunction

endpackage

// ----- rtl/core/bsc_req_if.sv -----
interface bsc_req_if import bsc_pkg::*; ();
   logic                       valid;
   logic                       ready;
   logic [OP_W-1:0]            operation;
   logic [PROC_W-1:0]          process;
   logic [RES_W-1:0]           resource;
   logic signed [AMOUNT_W-1:0] amount;
   logic                       last;

   modport source (output valid, operation, process, resource, amount, last, input ready);
   modport sink (input valid, operation, process, resource, amount, last, output ready);
endinterface

// ----- rtl/core/bsc_rsp_if.sv -----
interface bsc_rsp_if import bsc_pkg::*; ();
   logic               valid;
   logic               ready;
   logic               granted;
   logic [PROC_W-1:0]  requester;
   logic [COUNT_W-1:0] finished_count;

   modport source (output valid, granted, requester, finished_count, input ready);
   modport sink (input valid, granted, requester, finished_count, output ready);
endinterface

// ----- rtl/core/bsc_ram.sv -----
module bsc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 32,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ----- rtl/core/bsc_ctrl.sv -----
module bsc_ctrl import bsc_pkg::*; #(
   parameter int PROCESSES = PROCESSES_DEF,
   parameter int RESOURCES = RESOURCES_DEF,
   localparam int PW = $clog2(PROCESSES),
   localparam int RW = (RESOURCES > 1) ? $clog2(RESOURCES) : 1
) (
   input  logic          clock,
   input  logic          reset,
   input  sts_type       sts,
   output ctl_type       ctl,
   output logic [PW-1:0] p_idx,
   output logic [RW-1:0] r_idx
);

   state_type     state_ff, state_in;
   logic [PW-1:0] p_ff, p_in;
   logic [RW-1:0] r_ff, r_in;
   logic          p_last, r_last;
   logic          adv_p;
   state_type     adv_state;
   logic [PW-1:0] adv_pval;

   assign p_last = (p_ff == PW'(PROCESSES - 1));
   assign r_last = (r_ff == RW'(RESOURCES - 1));

   // moving on to the next row of the check
   assign adv_p = (state_ff == ST_CRD && sts.fin) || (state_ff == ST_CUSE && sts.fail)
               || (state_ff == ST_AUSE && r_last);

   always_comb begin
      if (p_last) begin
         adv_pval  = '0;
         adv_state = sts.progress ? ST_CRD : ST_DECIDE;
      end else begin
         adv_pval  = p_ff + PW'(1);
         adv_state = ST_CRD;
      end
   end

   always_comb begin
      state_in = state_ff;
      p_in     = p_ff;
      r_in     = r_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            r_in = r_last ? '0 : r_ff + RW'(1);
            if (r_last) begin
               p_in = p_last ? '0 : p_ff + PW'(1);
               if (p_last) begin
                  state_in = ST_IDLE;
               end
            end
         end
         ST_IDLE: begin
            if (sts.last_go) begin
               p_in     = '0;
               r_in     = '0;
               state_in = sts.proc_ok ? ST_WRD : ST_PCLR;
            end
         end
         ST_WRD: state_in = ST_WUSE;
         ST_WUSE: begin
            if (p_last) begin
               p_in = '0;
               r_in = r_last ? '0 : r_ff + RW'(1);
               state_in = r_last ? ST_CRD : ST_WRD;
            end else begin
               p_in     = p_ff + PW'(1);
               state_in = ST_WRD;
            end
         end
         ST_CRD: begin
            if (adv_p) begin
               p_in     = adv_pval;
               state_in = adv_state;
            end else begin
               state_in = ST_CUSE;
            end
         end
         ST_CUSE: begin
            if (adv_p) begin
               r_in     = '0;
               p_in     = adv_pval;
               state_in = adv_state;
            end else if (r_last) begin
               r_in     = '0;
               state_in = ST_ARD;
            end else begin
               r_in     = r_ff + RW'(1);
               state_in = ST_CRD;
            end
         end
         ST_ARD: state_in = ST_AUSE;
         ST_AUSE: begin
            if (adv_p) begin
               r_in     = '0;
               p_in     = adv_pval;
               state_in = adv_state;
            end else begin
               r_in     = r_ff + RW'(1);
               state_in = ST_ARD;
            end
         end
         ST_DECIDE: begin
            r_in     = '0;
            state_in = sts.grant ? ST_MRD : ST_PCLR;
         end
         ST_MRD: state_in = ST_MUSE;
         ST_MUSE: begin
            r_in     = r_last ? '0 : r_ff + RW'(1);
            state_in = r_last ? ST_PCLR : ST_MRD;
         end
         ST_PCLR: begin
            r_in = r_last ? '0 : r_ff + RW'(1);
            if (r_last) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (sts.rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_CLEAR;
      endcase
   end

   always_comb begin
      ctl.state    = state_ff;
      ctl.new_pass = adv_p && p_last && sts.progress;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         p_ff     <= '0;
         r_ff     <= '0;
      end else begin
         state_ff <= state_in;
         p_ff     <= p_in;
         r_ff     <= r_in;
      end
   end

   assign p_idx = p_ff;
   assign r_idx = r_ff;

endmodule

// ----- rtl/core/bankers_safety_check.sv -----
// banker's algorithm admission unit
// req_chan: one item per transfer. operation 0 loads a resource total,
//   1 loads a maximum claim, 2 is one element of a signed request vector
//   (negative releases). the element with last set starts the safety check.
// rsp_chan: one result per last request element: granted, requester and
//   the number of processes the check could run to completion.
// after reset a clearing pass writes zero to every claim, allocation, total
//   and pending entry, with req_chan not ready until the pass ends.
// req_chan stays ready after a load item or a plain request element.
// a last element first builds the work vector (WRD, WUSE), then makes up
//   to P+1 passes over the rows of the check, each unfinished row testing
//   its need and, if it fits, returning its allocation to the work vector;
//   then a grant, if given, is committed and the pending vector is cleared.
//   all of it runs through one read and one write port of each memory.
// the result sits in an output register; a new item is taken while it
//   waits, but the next decision holds until rsp_chan takes the previous one
module bankers_safety_check import bsc_pkg::*; #(
   parameter int PROCESSES = PROCESSES_DEF,
   parameter int RESOURCES = RESOURCES_DEF
) (
   input  logic      clock,
   input  logic      reset,
   bsc_req_if.sink   req_chan,
   bsc_rsp_if.source rsp_chan
);

   localparam int PW = $clog2(PROCESSES);
   localparam int RW = (RESOURCES > 1) ? $clog2(RESOURCES) : 1;
   localparam int CW = $clog2(PROCESSES + 1);
   // work vector: total minus up to PROCESSES allocations of 255
   localparam int WW = PW + 10;
   localparam int RDEPTH = 1 << RW;
   localparam int MDEPTH = PROCESSES << RW;

   ctl_type       ctl;
   sts_type       sts;
   logic [PW-1:0] p_idx;
   logic [RW-1:0] r_idx;

   // input decode
   logic             accept;
   logic [IDX_W-1:0] proc_ext, res_ext;
   logic             proc_ok, res_ok;
   logic [UNIT_W-1:0] amt_unit;
   logic             last_go;

   // memory ports
   logic                       claim_we, alloc_we, total_we, pend_we, trial_we, work_we;
   logic [PW+RW-1:0]           claim_waddr, alloc_waddr, row_addr;
   logic [RW-1:0]              total_waddr, pend_waddr;
   logic [UNIT_W-1:0]          claim_wdata, alloc_wdata, total_wdata, trial_wdata;
   logic [AMOUNT_W-1:0]        pend_wdata;
   logic [WW-1:0]              work_wdata;
   logic [UNIT_W-1:0]          claim_q, alloc_q, total_q, trial_q;
   logic [AMOUNT_W-1:0]        pend_raw;
   logic [WW-1:0]              work_raw;
   logic signed [WW-1:0]       work_q;

   // datapath
   logic                   clearing, is_req_row;
   logic signed [AMOUNT_W:0] trial_sum;
   logic [UNIT_W-1:0]      ta_build, ta_check;
   logic signed [WW-1:0]   acc_ff, acc_base, acc_next;
   logic signed [AMOUNT_W-1:0] need;
   logic signed [WW-1:0]   need_w;
   logic                   fail, row_fits;
   logic [PROCESSES-1:0]   finished_ff;
   logic                   progress_ff, over_ff, grant_ff, grant_ok;
   logic [CW-1:0]          done_ff;
   logic [PROC_W-1:0]      rproc_ff;
   logic [PW-1:0]          rproc;
   logic                   rsp_free;

   // output register
   logic                   rsp_valid_ff;
   logic                   granted_ff;
   logic [PROC_W-1:0]      requester_ff;
   logic [COUNT_W-1:0]     count_ff;

   bsc_ctrl #(.PROCESSES(PROCESSES), .RESOURCES(RESOURCES)) u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .ctl   (ctl),
      .p_idx (p_idx),
      .r_idx (r_idx)
   );

   // ---------------- input side ----------------
   assign req_chan.ready = (ctl.state == ST_IDLE);
   assign accept   = req_chan.valid && req_chan.ready;
   assign proc_ext = IDX_W'(req_chan.process);
   assign res_ext  = IDX_W'(req_chan.resource);
   assign proc_ok  = (proc_ext < IDX_W'(PROCESSES));
   assign res_ok   = (res_ext < IDX_W'(RESOURCES));
   // negative loads store zero
   assign amt_unit = req_chan.amount[AMOUNT_W-1] ? '0 : req_chan.amount[UNIT_W-1:0];
   assign last_go  = accept && (req_chan.operation == OP_REQUEST) && req_chan.last;

   assign clearing = (ctl.state == ST_CLEAR);
   assign row_addr = {p_idx, r_idx};
   assign rproc    = PW'(IDX_W'(rproc_ff));
   assign is_req_row = (p_idx == rproc);

   // ---------------- memories ----------------
   // maximum claims, one row per process
   assign claim_we    = clearing || (accept && req_chan.operation == OP_CLAIM && res_ok && proc_ok);
   assign claim_waddr = clearing ? row_addr : {proc_ext[PW-1:0], res_ext[RW-1:0]};
   assign claim_wdata = clearing ? '0 : amt_unit;

   bsc_ram #(.WIDTH(UNIT_W), .DEPTH(MDEPTH)) u_claim (
      .clock (clock), .we (claim_we), .waddr (claim_waddr), .wdata (claim_wdata),
      .raddr (row_addr), .rdata (claim_q)
   );

   // committed allocations; commit writes the requester's row from the trial row
   assign alloc_we    = clearing || (ctl.state == ST_MUSE);
   assign alloc_waddr = clearing ? row_addr : {rproc, r_idx};
   assign alloc_wdata = clearing ? '0 : trial_q;

   bsc_ram #(.WIDTH(UNIT_W), .DEPTH(MDEPTH)) u_alloc (
      .clock (clock), .we (alloc_we), .waddr (alloc_waddr), .wdata (alloc_wdata),
      .raddr (row_addr), .rdata (alloc_q)
   );

   assign total_we    = clearing || (accept && req_chan.operation == OP_TOTAL && res_ok);
   assign total_waddr = clearing ? r_idx : res_ext[RW-1:0];
   assign total_wdata = clearing ? '0 : amt_unit;

   bsc_ram #(.WIDTH(UNIT_W), .DEPTH(RDEPTH)) u_total (
      .clock (clock), .we (total_we), .waddr (total_waddr), .wdata (total_wdata),
      .raddr (r_idx), .rdata (total_q)
   );

   // pending request vector, zeroed after every decision
   assign pend_we    = clearing || (ctl.state == ST_PCLR)
                    || (accept && req_chan.operation == OP_REQUEST && res_ok);
   assign pend_waddr = accept ? res_ext[RW-1:0] : r_idx;
   assign pend_wdata = accept ? req_chan.amount : '0;

   bsc_ram #(.WIDTH(AMOUNT_W), .DEPTH(RDEPTH)) u_pend (
      .clock (clock), .we (pend_we), .waddr (pend_waddr), .wdata (pend_wdata),
      .raddr (r_idx), .rdata (pend_raw)
   );

   // tentative allocation row of the requester
   assign trial_we    = (ctl.state == ST_WUSE) && is_req_row;
   assign trial_wdata = ta_build;

   bsc_ram #(.WIDTH(UNIT_W), .DEPTH(RDEPTH)) u_trial (
      .clock (clock), .we (trial_we), .waddr (r_idx), .wdata (trial_wdata),
      .raddr (r_idx), .rdata (trial_q)
   );

   // work vector of the check
   assign work_we    = ((ctl.state == ST_WUSE) && (p_idx == PW'(PROCESSES - 1)))
                    || (ctl.state == ST_AUSE);
   assign work_wdata = (ctl.state == ST_WUSE) ? acc_next
                                             : WW'(work_q + $signed(WW'(ta_check)));

   bsc_ram #(.WIDTH(WW), .DEPTH(RDEPTH)) u_work (
      .clock (clock), .we (work_we), .waddr (r_idx), .wdata (work_wdata),
      .raddr (r_idx), .rdata (work_raw)
   );

   assign work_q = $signed(work_raw);

   // ---------------- work vector build ----------------
   // allocation with the request applied, clamped to 0..255
   assign trial_sum = $signed({2'b00, alloc_q}) + $signed({pend_raw[AMOUNT_W-1], pend_raw});
   assign ta_build  = is_req_row ? clamp_unit(trial_sum) : alloc_q;
   assign acc_base  = (p_idx == '0) ? $signed(WW'(total_q)) : acc_ff;
   assign acc_next  = acc_base - $signed(WW'(ta_build));

   always_ff @(posedge clock) begin
      if (ctl.state == ST_WUSE) begin
         acc_ff <= acc_next;
      end
   end

   // ---------------- safety check ----------------
   assign ta_check = is_req_row ? trial_q : alloc_q;
   // allocation above claim counts as zero need
   assign need     = $signed({1'b0, claim_q}) - $signed({1'b0, ta_check});
   assign need_w   = need[AMOUNT_W-1] ? '0 : $signed(WW'(need[UNIT_W-1:0]));
   assign fail     = need_w > work_q;
   assign row_fits = (ctl.state == ST_CUSE) && !fail && (r_idx == RW'(RESOURCES - 1));
   assign grant_ok = (done_ff == CW'(PROCESSES)) && !over_ff;

   always_ff @(posedge clock) begin
      if (last_go) begin
         finished_ff <= '0;
         progress_ff <= 1'b0;
         done_ff     <= '0;
         over_ff     <= 1'b0;
         grant_ff    <= 1'b0;
         rproc_ff    <= req_chan.process;
      end else begin
         if (row_fits) begin
            finished_ff[p_idx] <= 1'b1;
            done_ff            <= done_ff + CW'(1);
            progress_ff        <= 1'b1;
         end else if (ctl.new_pass) begin
            progress_ff <= 1'b0;
         end
         // over-commitment: some resource already short before the check
         if (work_we && (ctl.state == ST_WUSE) && acc_next < 0) begin
            over_ff <= 1'b1;
         end
         if (ctl.state == ST_DECIDE) begin
            grant_ff <= grant_ok;
         end
      end
   end

   // ---------------- status to the sequencer ----------------
   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;

   always_comb begin
      sts.last_go  = last_go;
      sts.proc_ok  = proc_ok;
      sts.fin      = finished_ff[p_idx];
      sts.fail     = fail;
      sts.progress = progress_ff;
      sts.grant    = grant_ok;
      sts.rsp_free = rsp_free;
   end

   // ---------------- result register ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ctl.state == ST_OUT && rsp_free) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.state == ST_OUT && rsp_free) begin
         granted_ff   <= grant_ff;
         requester_ff <= rproc_ff;
         // count saturates at the field's top
         count_ff     <= (done_ff > CW'(31)) ? COUNT_W'(31) : COUNT_W'(done_ff);
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.granted        = granted_ff;
   assign rsp_chan.requester      = requester_ff;
   assign rsp_chan.finished_count = count_ff;

endmodule

// ----- tb/sv/tb_bankers_safety_check.sv -----
module tb_bankers_safety_check;
   import bsc_pkg::*;

   localparam int NPROC = PROCESSES_DEF;
   localparam int NRES = RESOURCES_DEF;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   // a decision steps through the memories row by row and resource by resource, so the budget is wide
   localparam longint CYCLE_LIMIT = 60_000_000;
   localparam int DRAIN_CYCLES = 200;

   typedef struct packed {
      logic               granted;
      logic [PROC_W-1:0]  requester;
      logic [COUNT_W-1:0] finished_count;
   } decision_type;

   logic clock;
   logic reset;

   bsc_req_if req_chan ();
   bsc_rsp_if rsp_chan ();

   bankers_safety_check u_top (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   // shadow copy of the admission state
   int unsigned total_sh [NRES];
   int unsigned claim_sh [NPROC][NRES];
   int unsigned alloc_sh [NPROC][NRES];
   int          pend_sh  [NRES];

   decision_type decision_q [$];

   int     fail_cnt;
   int     items_sent;
   int     decisions_seen;
   int     grants_seen;
   longint cycle_cnt;
   int     send_idle_pct;
   int     rsp_stall_pct;

   // clock and cycle limit
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_cnt <= cycle_cnt + 1;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("[bankers_safety_check] ERROR");
         $finish;
      end
   end

   function automatic int unsigned clamp8(input int v);
      if (v < 0) return 0;
      if (v > 255) return 255;
      return v;
   endfunction

   // applies the pending vector tentatively, runs the safety check, commits a grant and clears the pending vector
   function automatic decision_type predict_decision(input int p);
      int unsigned  trial [NPROC][NRES];
      int           work [NRES];
      bit           done_flag [NPROC];
      bit           over;
      bit           progress;
      bit           fits;
      int           need;
      int           done_cnt;
      decision_type d;
      over = 0;
      done_cnt = 0;
      for (int i = 0; i < NPROC; i++) begin
         done_flag[i] = 0;
         for (int r = 0; r < NRES; r++) trial[i][r] = alloc_sh[i][r];
      end
      for (int r = 0; r < NRES; r++) trial[p][r] = clamp8(int'(alloc_sh[p][r]) + pend_sh[r]);
      for (int r = 0; r < NRES; r++) begin
         work[r] = total_sh[r];
         for (int i = 0; i < NPROC; i++) work[r] -= trial[i][r];
         if (work[r] < 0) over = 1;
      end
      progress = 1;
      while (progress) begin
         progress = 0;
         for (int i = 0; i < NPROC; i++) begin
            if (!done_flag[i]) begin
               fits = 1;
               for (int r = 0; r < NRES; r++) begin
                  need = int'(claim_sh[i][r]) - int'(trial[i][r]);
                  if (need < 0) need = 0;
                  if (need > work[r]) fits = 0;
               end
               if (fits) begin
                  done_flag[i] = 1;
                  done_cnt++;
                  progress = 1;
                  for (int r = 0; r < NRES; r++) work[r] += trial[i][r];
               end
            end
         end
      end
      d.granted = (done_cnt == NPROC) && !over;
      if (d.granted) begin
         for (int i = 0; i < NPROC; i++)
            for (int r = 0; r < NRES; r++) alloc_sh[i][r] = trial[i][r];
      end
      for (int r = 0; r < NRES; r++) pend_sh[r] = 0;
      d.requester = p[PROC_W-1:0];
      d.finished_count = done_cnt[COUNT_W-1:0];
      return d;
   endfunction

   // one transfer on req_chan, with a random idle gap ahead of it
   task automatic send_item(input logic [OP_W-1:0] op, input int p, input int r,
                            input int amt, input bit lst);
      int gap;
      gap = 0;
      while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct && gap < 40) gap++;
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      // update the shadow state in transfer order
      case (op)
         OP_TOTAL:   total_sh[r] = clamp8(amt);
         OP_CLAIM:   claim_sh[p][r] = clamp8(amt);
         OP_REQUEST: begin
            pend_sh[r] = amt;
            if (lst) decision_q.push_back(predict_decision(p));
         end
         default: ;
      endcase
      req_chan.valid     <= 1'b1;
      req_chan.operation <= op;
      req_chan.process   <= p[PROC_W-1:0];
      req_chan.resource  <= r[RES_W-1:0];
      req_chan.amount    <= amt[AMOUNT_W-1:0];
      req_chan.last      <= lst;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic drain_decisions();
      req_chan.valid <= 1'b0;
      while (decision_q.size() != 0) @(posedge clock);
   endtask

   // receiver stall and result checker
   always @(posedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= ($urandom_range(99) >= rsp_stall_pct);
         if (rsp_chan.valid && rsp_chan.ready) begin
            decisions_seen++;
            if (decision_q.size() == 0) begin
               $error("unexpected result requester=%0d", rsp_chan.requester);
               fail_cnt++;
            end else begin
               decision_type d;
               d = decision_q.pop_front();
               if (rsp_chan.granted !== d.granted) begin
                  $error("granted expected %0d actual %0d", d.granted, rsp_chan.granted);
                  fail_cnt++;
               end
               if (rsp_chan.requester !== d.requester) begin
                  $error("requester expected %0d actual %0d", d.requester,
                         rsp_chan.requester);
                  fail_cnt++;
               end
               if (rsp_chan.finished_count !== d.finished_count) begin
                  $error("finished_count expected %0d actual %0d", d.finished_count,
                         rsp_chan.finished_count);
                  fail_cnt++;
               end
               if (d.granted) grants_seen++;
            end
         end
      end
   end

   // extremes and each special case
   task automatic test_directed();
      for (int r = 0; r < NRES; r++) send_item(OP_TOTAL, 0, r, 200, 0);
      send_item(OP_TOTAL, 0, 31, 255, 0);
      // negative total stores zero
      send_item(OP_TOTAL, 0, 5, -255, 0);
      send_item(OP_CLAIM, 0, 5, -1, 0);
      send_item(OP_CLAIM, 15, 31, 255, 0);
      send_item(OP_CLAIM, 3, 2, 20, 0);
      // unused operation does nothing
      send_item(OP_UNUSED, 9, 17, 77, 1);
      // empty request
      send_item(OP_REQUEST, 7, 0, 0, 1);
      // plain grant
      send_item(OP_REQUEST, 3, 2, 10, 1);
      // repeated element overwrites
      send_item(OP_REQUEST, 3, 2, 100, 0);
      send_item(OP_REQUEST, 3, 2, 5, 1);
      // release below zero clamps
      send_item(OP_REQUEST, 3, 2, -255, 1);
      // allocation above claim, then saturation and over-commitment
      send_item(OP_REQUEST, 15, 31, 255, 1);
      send_item(OP_REQUEST, 15, 31, 255, 1);
      send_item(OP_REQUEST, 1, 5, 1, 1);
      // pool of zero with a claim pending
      send_item(OP_TOTAL, 0, 5, 0, 0);
      send_item(OP_CLAIM, 4, 5, 3, 0);
      send_item(OP_REQUEST, 4, 5, -256, 1);
      send_item(OP_CLAIM, 4, 5, 0, 0);
      send_item(OP_REQUEST, 15, 31, -255, 1);
   endtask

   // mostly well-formed request sequences on top of random loads
   task automatic test_random(input int n_items, input int idle_pct, input int stall_pct);
      int kind;
      int p;
      int len;
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      for (int k = 0; k < n_items; ) begin
         kind = $urandom_range(99);
         p = $urandom_range(NPROC - 1);
         if (kind < 40) begin
            if ($urandom_range(9) == 0) send_item(OP_TOTAL, 0, $urandom_range(NRES - 1),
                                                  $signed(9'($urandom)), 0);
            else send_item(OP_TOTAL, 0, $urandom_range(NRES - 1), $urandom_range(120, 255), 0);
            k++;
         end else if (kind < 80) begin
            if ($urandom_range(9) == 0) send_item(OP_CLAIM, p, $urandom_range(NRES - 1),
                                                  $signed(9'($urandom)), 0);
            else send_item(OP_CLAIM, p, $urandom_range(NRES - 1), $urandom_range(0, 30), 0);
            k++;
         end else if (kind < 83) begin
            send_item(OP_UNUSED, p, $urandom_range(NRES - 1), $signed(9'($urandom)),
                      $urandom_range(1));
         end else begin
            len = $urandom_range(1, 4);
            for (int e = 0; e < len; e++) begin
               if ($urandom_range(7) == 0)
                  send_item(OP_REQUEST, p, $urandom_range(NRES - 1), $signed(9'($urandom)),
                            e == len - 1);
               else
                  send_item(OP_REQUEST, p, $urandom_range(NRES - 1), $urandom_range(0, 30) - 10,
                            e == len - 1);
               k++;
            end
         end
      end
   endtask

   // sender holds off until every decision is back, then resumes
   task automatic test_hold_off();
      send_idle_pct = 0;
      rsp_stall_pct = 50;
      send_item(OP_REQUEST, 2, 1, 3, 1);
      drain_decisions();
      send_item(OP_REQUEST, 2, 1, -3, 1);
   endtask

   initial begin
      reset = 1'b1;
      req_chan.valid = 1'b0;
      req_chan.operation = OP_TOTAL;
      req_chan.process = '0;
      req_chan.resource = '0;
      req_chan.amount = '0;
      req_chan.last = 1'b0;
      rsp_chan.ready = 1'b0;
      cycle_cnt = 0;
      fail_cnt = 0;
      items_sent = 0;
      decisions_seen = 0;
      grants_seen = 0;
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      for (int r = 0; r < NRES; r++) begin
         total_sh[r] = 0;
         pend_sh[r] = 0;
         for (int i = 0; i < NPROC; i++) begin
            claim_sh[i][r] = 0;
            alloc_sh[i][r] = 0;
         end
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      test_directed();
      test_random(225, 0, 0);
      test_random(225, 85, 0);
      test_hold_off();
      test_random(225, 0, 85);
      test_random(225, 23, 23);

      // let the last decision come back
      drain_decisions();
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("covered %0d transfers in, %0d decisions (%0d grants) over four idle phases",
               items_sent, decisions_seen, grants_seen);
      if (fail_cnt == 0) begin
         $display("[bankers_safety_check] OK");
      end else begin
         $display("[bankers_safety_check] ERROR");
      end
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/core/bsc_pkg.sv
rtl/core/bsc_req_if.sv
rtl/core/bsc_rsp_if.sv
rtl/core/bsc_ram.sv
rtl/core/bsc_ctrl.sv
rtl/core/bankers_safety_check.sv
tb/sv/tb_bankers_safety_check.sv
